// ===== hw/rtl/ring_deque_with_match_dump_assert.svh =====
// assertion macros for the ring deque
`ifndef RING_DEQUE_WITH_MATCH_DUMP_ASSERT_SVH
`define RING_DEQUE_WITH_MATCH_DUMP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RDQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdq assertion failed");

// next-cycle implication, checked out of reset
`define RDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdq assertion failed");

`endif

// ===== hw/rtl/rdq_pkg.sv =====
// shared constants and types for the ring deque
package rdq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_DUMP_FWD   = 3'd2;
  localparam logic [2:0] ACT_DUMP_BWD   = 3'd3;
  localparam logic [2:0] ACT_MATCH_FWD  = 3'd4;
  localparam logic [2:0] ACT_MATCH_BWD  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_SHR  = 2'd1;
  localparam logic [1:0] OP_SHL  = 2'd2;
  localparam logic [1:0] OP_LOAD = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [1:0] op;
    logic       from_in;
    word_t      ld_d;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/ring_deque_with_match_dump.sv =====
// ring deque with full and match-anchored dumps, top level
//
// Items enter on start when busy is low. The live words sit in a row of cells
// in front-to-back order; dumps and searches rotate that row one place per
// cycle and every result is taken from the front cell. A push to the front
// shifts the row right and a push to the back loads the tail cell; a forward
// dump reads the words front first, a backward dump first turns the back word
// to the front, and a match dump rotates until the key is in front, then dumps
// every live word from the hit on and rotates the row back into order (a miss
// ends in a not-found status). Each result is on the out_ ports for exactly
// one cycle, marked by out_valid, registered in the cycle after the step that
// produced it; the receiver cannot stall and must take every item.
`include "ring_deque_with_match_dump_assert.svh"

module ring_deque_with_match_dump (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic signed [31:0] out_element,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import rdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;
  localparam logic [1:0] S_REST = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] rot_r, rot_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             bwd_r, bwd_nxt;
  word_t            key_r, key_nxt;

  logic               ov_r, ov_nxt;
  logic signed [31:0] oe_r, oe_nxt;
  logic [1:0]         os_r, os_nxt;
  logic               ol_r, ol_nxt;

  cell_ctl_t        ctl;
  logic [IDX_W-1:0] wr_idx;
  word_t            head_q;
  logic             accept;
  logic [IDX_W-1:0] rot_inc, rot_dec;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign wr_idx = cnt_r[IDX_W-1:0];

  assign rot_inc = ((CNT_W'(rot_r) + CNT_W'(1)) == cnt_r) ? '0 : rot_r + IDX_W'(1);
  assign rot_dec = (rot_r == '0) ? IDX_W'(cnt_r - CNT_W'(1)) : rot_r - IDX_W'(1);

  rdq_chain u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .cnt    (cnt_r),
    .wr_idx (wr_idx),
    .head_q (head_q)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rot_nxt     = rot_r;
    rem_nxt     = rem_r;
    bwd_nxt     = bwd_r;
    key_nxt     = key_r;
    ov_nxt      = 1'b0;
    oe_nxt      = '0;
    os_nxt      = ST_OK;
    ol_nxt      = 1'b0;
    ctl.op      = OP_HOLD;
    ctl.from_in = 1'b0;
    ctl.ld_d    = WORD_BITS'(in_value);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_PUSH_FRONT || in_action == ACT_PUSH_BACK) begin
            if (cnt_r == CNT_W'(DEPTH)) begin
              ov_nxt = 1'b1;
              os_nxt = ST_FULL;
              ol_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
              if (in_action == ACT_PUSH_FRONT) begin
                ctl.op      = OP_SHR;
                ctl.from_in = 1'b1;
              end else begin
                ctl.op = OP_LOAD;
              end
            end
          end else if (in_action == ACT_DUMP_FWD || in_action == ACT_DUMP_BWD ||
                       in_action == ACT_MATCH_FWD || in_action == ACT_MATCH_BWD) begin
            if (cnt_r == '0) begin
              ov_nxt = 1'b1;
              os_nxt = ST_EMPTY;
              ol_nxt = 1'b1;
            end else begin
              rem_nxt = cnt_r;
              rot_nxt = '0;
              key_nxt = WORD_BITS'(in_value);
              bwd_nxt = (in_action == ACT_DUMP_BWD) || (in_action == ACT_MATCH_BWD);
              case (in_action)
                ACT_DUMP_FWD: state_nxt = S_DUMP;
                ACT_DUMP_BWD: begin
                  ctl.op    = OP_SHR;
                  rot_nxt   = IDX_W'(cnt_r - CNT_W'(1));
                  state_nxt = S_DUMP;
                end
                default: state_nxt = S_SRCH;
              endcase
            end
          end
        end
      end
      S_SRCH: begin
        if (head_q == key_r) begin
          rem_nxt   = cnt_r;
          state_nxt = S_DUMP;
        end else begin
          ctl.op  = OP_SHL;
          rot_nxt = rot_inc;
          rem_nxt = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            ov_nxt    = 1'b1;
            os_nxt    = ST_NOTFOUND;
            ol_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        ov_nxt  = 1'b1;
        oe_nxt  = signed'(32'(head_q));
        os_nxt  = ST_OK;
        ol_nxt  = (rem_r == CNT_W'(1));
        ctl.op  = bwd_r ? OP_SHR : OP_SHL;
        rot_nxt = bwd_r ? rot_dec : rot_inc;
        rem_nxt = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt = (rot_nxt == '0) ? S_IDLE : S_REST;
        end
      end
      S_REST: begin
        ctl.op  = OP_SHL;
        rot_nxt = rot_inc;
        if (rot_inc == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rot_r   <= '0;
      rem_r   <= '0;
      bwd_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rot_r   <= rot_nxt;
      rem_r   <= rem_nxt;
      bwd_r   <= bwd_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    oe_r  <= oe_nxt;
    os_r  <= os_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid   = ov_r;
  assign out_element = oe_r;
  assign out_status  = os_r;
  assign out_last    = ol_r;

  `RDQ_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `RDQ_ASSERT_IMPL(a_busy_nonempty, state_r != S_IDLE, cnt_r != '0)
  `RDQ_ASSERT_IMPL(a_status_last, out_valid && out_status != ST_OK, out_last)
  `RDQ_ASSERT_NEXT(a_push_count,
    accept && (in_action == ACT_PUSH_BACK) && (cnt_r != CNT_W'(DEPTH)),
    cnt_r == $past(cnt_r) + CNT_W'(1))

endmodule

// ===== hw/rtl/rdq_cell.sv =====
// one storage cell of the deque chain
module rdq_cell (
  input  logic              clk,
  input  rdq_pkg::cell_ctl_t ctl,
  input  rdq_pkg::word_t    left_d,
  input  rdq_pkg::word_t    right_d,
  input  rdq_pkg::word_t    head_d,
  input  logic              is_tail,
  input  logic              ld_en,
  output rdq_pkg::word_t    data_q
);
  import rdq_pkg::*;

  word_t data_r;
  word_t data_nxt;

  always_comb begin
    case (ctl.op)
      OP_HOLD: data_nxt = data_r;
      OP_SHR:  data_nxt = left_d;
      OP_SHL:  data_nxt = is_tail ? head_d : right_d;
      OP_LOAD: data_nxt = ld_en ? ctl.ld_d : data_r;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== hw/rtl/rdq_chain.sv =====
// row of cells holding the live window in front-to-back order
module rdq_chain (
  input  logic                      clk,
  input  rdq_pkg::cell_ctl_t        ctl,
  input  logic [rdq_pkg::CNT_W-1:0] cnt,
  input  logic [rdq_pkg::IDX_W-1:0] wr_idx,
  output rdq_pkg::word_t            head_q
);
  import rdq_pkg::*;

  word_t             data_q [DEPTH];
  logic [IDX_W-1:0]  tail_idx;
  word_t             tail_d;
  word_t             first_left;

  assign tail_idx   = IDX_W'(cnt - CNT_W'(1));
  assign tail_d     = data_q[tail_idx];
  assign first_left = ctl.from_in ? ctl.ld_d : tail_d;
  assign head_q     = data_q[0];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      rdq_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .left_d  ((i == 0) ? first_left : data_q[(i + DEPTH - 1) % DEPTH]),
        .right_d (data_q[(i + 1) % DEPTH]),
        .head_d  (data_q[0]),
        .is_tail (tail_idx == IDX_W'(i)),
        .ld_en   (wr_idx == IDX_W'(i)),
        .data_q  (data_q[i])
      );
    end
  endgenerate

endmodule
